/* hw/rtl/hcodec_pkg.sv */
`timescale 1ns / 1ps

package hcodec_pkg;

  localparam int CODE_W  = 63;
  localparam int DATA_W  = 57;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 6;
  localparam int GROUP_N = 6;

  localparam logic [LEN_W-1:0] DATA_LEN_MAX   = 6'd57;
  localparam logic [LEN_W-1:0] CODE_LEN_RESET = 6'd63;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BEYOND    = 2'd2
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] mask;
  } code_cfg_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  err_pos;
    logic [CODE_W-1:0] code;
  } result_t;

  // positions 1..CODE_W whose index has bit g set
  function automatic logic [CODE_W-1:0] group_mask(input int g);
    logic [CODE_W-1:0] w;
    w = '0;
    for (int k = 1; k <= CODE_W; k++) begin
      if (((k >> g) & 1) != 0) w[k-1] = 1'b1;
    end
    return w;
  endfunction

  // place data bits on the non-power-of-two positions in order
  function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] d);
    logic [CODE_W-1:0] w;
    int j;
    w = '0;
    j = 0;
    for (int k = 1; k <= CODE_W; k++) begin
      if ((k & (k - 1)) != 0) begin
        w[k-1] = d[j];
        j++;
      end
    end
    return w;
  endfunction

  // codeword length n = m + r for the requested data length
  function automatic logic [LEN_W-1:0] code_len(input logic [LEN_W-1:0] m);
    logic [LEN_W:0] me;
    logic [2:0]     r_sel;
    if (m == '0) begin
      me = 7'd1;
    end else if (m > DATA_LEN_MAX) begin
      me = {1'b0, DATA_LEN_MAX};
    end else begin
      me = {1'b0, m};
    end
    r_sel = 3'd6;
    for (int t = GROUP_N; t >= 0; t--) begin
      if ((1 << t) >= (int'(me) + t + 1)) r_sel = 3'(t);
    end
    return LEN_W'(me + {4'd0, r_sel});
  endfunction

  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] n);
    logic [64:0] w;
    w = (65'd1 << n) - 65'd1;
    return w[CODE_W-1:0];
  endfunction

endpackage

/* hw/rtl/hcodec_cfg.sv */
`timescale 1ns / 1ps

module hcodec_cfg
  import hcodec_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  output code_cfg_t        cfg
);

  code_cfg_t code_cfg;
  logic [LEN_W-1:0] len_next;

  assign len_next = code_len(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_cfg.len  <= CODE_LEN_RESET;
      code_cfg.mask <= '1;
    end else if (cfg_we) begin
      code_cfg.len  <= len_next;
      code_cfg.mask <= code_mask(len_next);
    end
  end

  assign cfg = code_cfg;

endmodule

/* hw/rtl/hcodec_core.sv */
`timescale 1ns / 1ps

module hcodec_core
  import hcodec_pkg::*;
(
  input  req_t              req,
  input  logic [DATA_W-1:0] data,
  input  logic [CODE_W-1:0] code,
  input  code_cfg_t         cfg,
  output result_t           res
);

  logic [CODE_W-1:0]  word;
  logic [GROUP_N-1:0] par;
  logic [CODE_W-1:0]  enc_word;
  logic [CODE_W-1:0]  flip;

  assign word = ((req == REQ_ENCODE) ? scatter(data) : code) & cfg.mask;

  always_comb begin
    for (int g = 0; g < GROUP_N; g++) begin
      par[g] = ^(word & group_mask(g));
    end
  end

  always_comb begin
    enc_word = word;
    for (int g = 0; g < GROUP_N; g++) begin
      if (par[g]) enc_word[(1 << g) - 1] = 1'b1;
    end
  end

  assign flip = (par == '0) ? '0 : (CODE_W'(1) << (par - POS_W'(1)));

  always_comb begin
    res.code    = word;
    res.err_pos = '0;
    res.status  = ST_OK;
    if (req == REQ_ENCODE) begin
      res.code = enc_word;
    end else begin
      res.err_pos = par;
      if (par != '0) begin
        if (par <= cfg.len) begin
          res.code   = word ^ flip;
          res.status = ST_CORRECTED;
        end else begin
          res.status = ST_BEYOND;
        end
      end
    end
  end

endmodule

/* hw/rtl/hamming_codec_unit.sv */
`timescale 1ns / 1ps

// Hamming single-error-correcting encoder and decoder.
// Input words arrive on the s_axis channel: tuser selects encode (0) or
// decode (1), tdata carries the data bits and the received codeword.
// Results leave on the m_axis channel: codeword, syndrome and status.
// cfg_we/cfg_wdata set the data length m; the codeword length n and its
// mask are worked out when the register is written. Write it only while
// no word is in flight.
// The accepting edge loads the input register; parity, syndrome and
// correction results are then loaded into the output register. A new
// word is taken every cycle while m_axis is drained.
// When m_axis_tready is low the result holds and the input register
// fills; s_axis_tready falls only when both stages hold a word.
// Reset empties both stages and sets the data length to 57 (n = 63).

module hamming_codec_unit
  import hcodec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // data_in[56:0], code_in[119:57]
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata    // code_out[62:0], error_position[68:63],
                                       // status[70:69], zero[71]
);

  code_cfg_t         cfg;
  logic              in_valid;
  req_t              in_req;
  logic [DATA_W-1:0] in_data;
  logic [CODE_W-1:0] in_code;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  logic              out_load;

  hcodec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hcodec_core u_core (
    .req  (in_req),
    .data (in_data),
    .code (in_code),
    .cfg  (cfg),
    .res  (res)
  );

  assign out_load      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req  <= req_t'(s_axis_tuser);
      in_data <= s_axis_tdata[DATA_W-1:0];
      in_code <= s_axis_tdata[DATA_W+CODE_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

endmodule
